// ===== rtl/core/csltp_pkg.sv =====
// shared types, constants and rounding helper for the texture code block
package csltp_pkg;

    localparam int PIX_W   = 8;
    localparam int XW      = 12;
    localparam int YW      = 13;
    localparam int TAU_W   = 16;
    localparam int CODE_W  = 7;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int NPAIRS  = 4;
    localparam int PROD_W  = 18;
    localparam int FRAC_W  = 17;
    localparam int NUM_W   = 25;
    localparam int RANGE_W = 9;

    // queue depths and count widths
    localparam int JQ_DEPTH = 4;
    localparam int OQ_DEPTH = 4;
    localparam int QCNT_W   = $clog2(JQ_DEPTH + 1);
    localparam int OCNT_W   = $clog2(OQ_DEPTH + 1);

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TAU_SCALE    = 2'd2;

    // reset values of the registers
    localparam logic [XW-1:0]    RST_WIDTH  = 12'd640;
    localparam logic [YW-1:0]    RST_HEIGHT = 13'd480;
    localparam logic [TAU_W-1:0] RST_TAU    = 16'd1966;

    // ternary digit codes
    localparam logic [1:0] TC_INSIDE = 2'd0;
    localparam logic [1:0] TC_ABOVE  = 2'd1;
    localparam logic [1:0] TC_BELOW  = 2'd3;

    localparam logic [CODE_W-1:0] PAIR_WEIGHT [NPAIRS] = '{7'd1, 7'd3, 7'd9, 7'd27};

    typedef struct packed {
        logic [XW-1:0] image_width;
        logic [YW-1:0] image_height;
    } geom_t;

    // one window ready for coding
    typedef struct packed {
        logic [PIX_W-1:0]             centre;
        logic [NPAIRS-1:0][PIX_W-1:0] pa;
        logic [NPAIRS-1:0][PIX_W-1:0] pb;
        logic                         eol;
        logic                         eoi;
    } job_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              eol;
        logic              eoi;
    } result_t;

    // q16 fraction rounded to nearest, ties to even
    function automatic logic [RANGE_W-1:0] round_q16_even(input logic [NUM_W-1:0] num);
        logic [RANGE_W-1:0] q;
        logic [15:0]        rem;
        q   = num[NUM_W-1:16];
        rem = num[15:0];
        if (rem > 16'h8000 || (rem == 16'h8000 && q[0]))
            q = q + RANGE_W'(1);
        return q;
    endfunction

endpackage

// ===== rtl/core/csltp_fifo.sv =====
// small first-in first-out queue with occupancy count
module csltp_fifo
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 4
    )
    (
        input  logic                         clk,
        input  logic                         rst_n,
        input  logic                         wr_en,
        input  logic [WIDTH-1:0]             wr_data,
        input  logic                         rd_en,
        output logic [WIDTH-1:0]             rd_data,
        output logic                         is_empty,
        output logic [$clog2(DEPTH+1)-1:0]   count
    );

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign do_wr = wr_en && (count_reg != CW'(DEPTH));
    assign do_rd = rd_en && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    assign rd_data  = mem[rd_ptr_reg];
    assign is_empty = (count_reg == '0);
    assign count    = count_reg;

endmodule

// ===== rtl/core/csltp_front.sv =====
// front end: raster counters, line buffers, 3x3 window and job issue
module csltp_front
    import csltp_pkg::*;
    #(
        parameter int MAX_WIDTH = 2048
    )
    (
        input  logic              clk,
        input  logic              rst_n,
        input  geom_t             geom,
        input  logic              push,
        input  logic [PIX_W-1:0]  pixel,
        output logic              full,
        input  logic [QCNT_W-1:0] jq_count,
        output logic              job_push,
        output job_t              job
    );

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SAT_W = ($clog2(MAX_WIDTH + 1) > XW) ? $clog2(MAX_WIDTH + 1) : XW;

    logic [PIX_W-1:0] line_above     [MAX_WIDTH];
    logic [PIX_W-1:0] line_two_above [MAX_WIDTH];

    logic [XW-1:0] iw1, w_eff;
    logic [YW-1:0] h_eff;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic          accept, in_w, in_h;
    logic [PIX_W-1:0] bot;
    logic [AW-1:0]    addr;

    // stage one
    logic             f1_valid_reg, f1_emit_reg, f1_eol_reg, f1_eoi_reg;
    logic             f1_x0_reg, f1_inw_reg, f1_y1_reg, f1_y2_reg;
    logic [AW-1:0]    f1_addr_reg;
    logic [PIX_W-1:0] f1_bot_reg;
    logic [PIX_W-1:0] rd1_reg, rd2_reg;

    logic [PIX_W-1:0] win_reg  [3][3];
    logic [PIX_W-1:0] win_next [3][3];
    logic [PIX_W-1:0] top_px, mid_px;

    assign iw1   = (geom.image_width == '0) ? XW'(1) : geom.image_width;
    assign w_eff = (SAT_W'(iw1) > SAT_W'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : iw1;
    assign h_eff = (geom.image_height == '0) ? YW'(1) : geom.image_height;

    // room for the word in stage one plus the new one
    assign full   = ((QCNT_W+1)'(jq_count) + (QCNT_W+1)'(f1_valid_reg))
                    >= (QCNT_W+1)'(JQ_DEPTH);
    assign accept = push && !full;

    assign in_w = (x_reg < w_eff);
    assign in_h = (y_reg < h_eff);
    assign bot  = (in_w && in_h) ? pixel : '0;
    assign addr = AW'(x_reg);

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (accept)
        begin
            if (!in_w)
            begin
                x_next = '0;
                y_next = in_h ? y_reg + YW'(1) : '0;
            end
            else
                x_next = x_reg + XW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg        <= '0;
            y_reg        <= '0;
            f1_valid_reg <= 1'b0;
            f1_emit_reg  <= 1'b0;
            f1_eol_reg   <= 1'b0;
            f1_eoi_reg   <= 1'b0;
            f1_x0_reg    <= 1'b0;
            f1_inw_reg   <= 1'b0;
            f1_y1_reg    <= 1'b0;
            f1_y2_reg    <= 1'b0;
        end
        else
        begin
            x_reg        <= x_next;
            y_reg        <= y_next;
            f1_valid_reg <= accept;
            if (accept)
            begin
                f1_emit_reg <= (x_reg != '0) && (y_reg != '0)
                               && (x_reg <= w_eff) && (y_reg <= h_eff);
                f1_eol_reg  <= (x_reg == w_eff);
                f1_eoi_reg  <= (x_reg == w_eff) && (y_reg == h_eff);
                f1_x0_reg   <= (x_reg == '0);
                f1_inw_reg  <= in_w;
                f1_y1_reg   <= (y_reg >= YW'(1));
                f1_y2_reg   <= (y_reg >= YW'(2));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_addr_reg <= addr;
            f1_bot_reg  <= bot;
        end
    end

    // line buffers: read and new pixel written at accept, shifted row written in the cycle after
    always_ff @(posedge clk)
    begin
        if (accept && in_w)
        begin
            rd1_reg          <= line_above[addr];
            line_above[addr] <= bot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_w)
            rd2_reg <= line_two_above[addr];
        if (f1_valid_reg && f1_inw_reg)
            line_two_above[f1_addr_reg] <= rd1_reg;
    end

    assign top_px = (f1_inw_reg && f1_y2_reg) ? rd2_reg : '0;
    assign mid_px = (f1_inw_reg && f1_y1_reg) ? rd1_reg : '0;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (f1_x0_reg)
            begin
                win_next[r][0] = '0;
                win_next[r][1] = '0;
            end
            else
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
        end
        win_next[0][2] = top_px;
        win_next[1][2] = mid_px;
        win_next[2][2] = f1_bot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (f1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= win_next[r][c];
        end
    end

    assign job_push   = f1_valid_reg && f1_emit_reg;
    assign job.centre = win_next[1][1];
    assign job.pa[0]  = win_next[1][2];
    assign job.pb[0]  = win_next[1][0];
    assign job.pa[1]  = win_next[2][2];
    assign job.pb[1]  = win_next[0][0];
    assign job.pa[2]  = win_next[2][1];
    assign job.pb[2]  = win_next[0][1];
    assign job.pa[3]  = win_next[2][0];
    assign job.pb[3]  = win_next[0][2];
    assign job.eol    = f1_eol_reg;
    assign job.eoi    = f1_eoi_reg;

endmodule

// ===== rtl/core/csltp_back.sv =====
// back end: pair products, centre range and ternary coding in two stages
module csltp_back
    import csltp_pkg::*;
    (
        input  logic              clk,
        input  logic              rst_n,
        input  logic [TAU_W-1:0]  tau_scale,
        input  logic              job_valid,
        input  job_t              job,
        output logic              job_pop,
        input  logic [OCNT_W-1:0] oq_count,
        output logic              res_push,
        output result_t           res
    );

    logic signed [PIX_W:0]  da [NPAIRS];
    logic signed [PIX_W:0]  db [NPAIRS];
    logic [FRAC_W-1:0]      lo_f, hi_f;

    logic                     b1_valid_reg, b2_valid_reg;
    logic signed [PROD_W-1:0] prod_reg [NPAIRS];
    logic [NUM_W-1:0]         lo_num_reg, hi_num_reg;
    logic                     b1_eol_reg, b1_eoi_reg;
    result_t                  b2_res_reg;

    logic [RANGE_W-1:0]       lo_r, hi_r, hi_c;
    logic signed [PROD_W-1:0] lo_s, hi_s;
    logic [1:0]               digit [NPAIRS];
    logic [CODE_W-1:0]        code;

    // words in flight count against output queue space
    assign job_pop = job_valid && (((OCNT_W+1)'(oq_count) + (OCNT_W+1)'(b1_valid_reg)
                     + (OCNT_W+1)'(b2_valid_reg)) < (OCNT_W+1)'(OQ_DEPTH));

    always_comb
    begin
        for (int k = 0; k < NPAIRS; k++)
        begin
            da[k] = signed'({1'b0, job.pa[k]}) - signed'({1'b0, job.centre});
            db[k] = signed'({1'b0, job.pb[k]}) - signed'({1'b0, job.centre});
        end
    end

    assign lo_f = 17'h10000 - {1'b0, tau_scale};
    assign hi_f = 17'h10000 + {1'b0, tau_scale};

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            for (int k = 0; k < NPAIRS; k++)
                prod_reg[k] <= PROD_W'(da[k] * db[k]);
            lo_num_reg <= NUM_W'(job.centre) * NUM_W'(lo_f);
            hi_num_reg <= NUM_W'(job.centre) * NUM_W'(hi_f);
            b1_eol_reg <= job.eol;
            b1_eoi_reg <= job.eoi;
        end
    end

    assign lo_r = round_q16_even(lo_num_reg);
    assign hi_r = round_q16_even(hi_num_reg);
    assign hi_c = (hi_r > RANGE_W'(255)) ? RANGE_W'(255) : hi_r;
    assign lo_s = signed'(PROD_W'(lo_r));
    assign hi_s = signed'(PROD_W'(hi_c));

    always_comb
    begin
        code = '0;
        for (int k = 0; k < NPAIRS; k++)
        begin
            if (prod_reg[k] < lo_s)
                digit[k] = TC_BELOW;
            else if (prod_reg[k] > hi_s)
                digit[k] = TC_ABOVE;
            else
                digit[k] = TC_INSIDE;
            code = code + CODE_W'(CODE_W'(digit[k]) * PAIR_WEIGHT[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_valid_reg)
        begin
            b2_res_reg.code <= code;
            b2_res_reg.eol  <= b1_eol_reg;
            b2_res_reg.eoi  <= b1_eoi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= job_pop;
            b2_valid_reg <= b1_valid_reg;
        end
    end

    assign res_push = b2_valid_reg;
    assign res      = b2_res_reg;

endmodule

// ===== rtl/core/cs_siltp_3x3_texture_code.sv =====
// top level: configuration registers, front end, job queue, back end and result queue
// path: a code passes front stage one, the job queue, both back end stages and the result queue to the consumer
// throughput: one pixel word per cycle while full stays low, set by the single line buffer port pair
// a row takes width+1 words and an image (height+1) rows including flush ticks
// reset: asynchronous, active low; clears counters, window, queues and config to defaults
// line buffers are not cleared; the top rows never read them before they are written
module cs_siltp_3x3_texture_code
    import csltp_pkg::*;
    #(
        parameter int MAX_WIDTH = 2048
    )
    (
        input  logic              clk,
        input  logic              rst_n,
        input  logic              cfg_write,
        input  logic [CIDX_W-1:0] cfg_index,
        input  logic [CFG_W-1:0]  cfg_data,
        input  logic              push,
        output logic              full,
        input  logic [PIX_W-1:0]  pixel,
        output logic              empty,
        input  logic              pop,
        output logic [CODE_W-1:0] pattern_code,
        output logic              end_of_line,
        output logic              end_of_image
    );

    // configuration registers
    logic [XW-1:0]    width_reg;
    logic [YW-1:0]    height_reg;
    logic [TAU_W-1:0] tau_reg;
    geom_t            geom;

    // front to queue to back
    logic              job_push, job_pop, jq_empty;
    job_t              job_in, job_out;
    logic [QCNT_W-1:0] jq_count;

    // back to result queue
    logic              res_push;
    result_t           res_in, res_out;
    logic [OCNT_W-1:0] oq_count;

    // a write beyond the register list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            tau_reg    <= RST_TAU;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[XW-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[YW-1:0];
                CFG_TAU_SCALE:    tau_reg    <= cfg_data[TAU_W-1:0];
                default:          ;
            endcase
        end
    end

    assign geom.image_width  = width_reg;
    assign geom.image_height = height_reg;

    // front end holds full while the job queue could not take its word
    csltp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .push     (push),
        .pixel    (pixel),
        .full     (full),
        .jq_count (jq_count),
        .job_push (job_push),
        .job      (job_in)
    );

    // short queue of finished windows between the two halves
    csltp_fifo #(.WIDTH($bits(job_t)), .DEPTH(JQ_DEPTH)) u_job_q
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_data  (job_in),
        .rd_en    (job_pop),
        .rd_data  (job_out),
        .is_empty (jq_empty),
        .count    (jq_count)
    );

    // back end pulls a window only when the result queue has space for it
    csltp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tau_scale (tau_reg),
        .job_valid (!jq_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .oq_count  (oq_count),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue faces the consumer
    csltp_fifo #(.WIDTH($bits(result_t)), .DEPTH(OQ_DEPTH)) u_res_q
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_push),
        .wr_data  (res_in),
        .rd_en    (pop),
        .rd_data  (res_out),
        .is_empty (empty),
        .count    (oq_count)
    );

    assign pattern_code = res_out.code;
    assign end_of_line  = res_out.eol;
    assign end_of_image = res_out.eoi;

endmodule

// ===== sim/tb_cs_siltp_3x3_texture_code.sv =====
// self-checking testbench for the 3x3 centre-symmetric ternary texture coder
`timescale 1ns / 1ps

module tb_cs_siltp_3x3_texture_code;
    import csltp_pkg::*;

    localparam int LINE_MAX   = 2048;
    // cycles with no accepted word before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // settling time after the last code, a margin over the path through the coder
    localparam int DRAIN_WAIT  = 8;

    // golden model of the coder plus the list of codes still owed by the dut
    class code_scoreboard;
        logic [XW-1:0]    width_reg;
        logic [YW-1:0]    height_reg;
        logic [TAU_W-1:0] tau_reg;
        logic [PIX_W-1:0] line_above [LINE_MAX];
        logic [PIX_W-1:0] line_two_above [LINE_MAX];
        logic [PIX_W-1:0] win [3][3];
        int unsigned      col;
        int unsigned      row;
        result_t          pending_codes [$];
        int               mismatches;

        function new();
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            tau_reg    = RST_TAU;
            foreach (line_above[i]) begin
                line_above[i]     = '0;
                line_two_above[i] = '0;
            end
            foreach (win[i, j]) win[i][j] = '0;
            col        = 0;
            row        = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = value[XW-1:0];
                CFG_IMAGE_HEIGHT: height_reg = value[YW-1:0];
                CFG_TAU_SCALE:    tau_reg    = value[TAU_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > LINE_MAX)
                return LINE_MAX;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int pending();
            return pending_codes.size();
        endfunction

        // q16 value to integer, nearest with ties to even
        function int q16_round_even(int unsigned num);
            int unsigned q;
            int unsigned rem;
            q   = num >> 16;
            rem = num & 32'hFFFF;
            if (rem > 32'h8000 || (rem == 32'h8000 && (q & 1) != 0))
                q++;
            return int'(q);
        endfunction

        function logic [1:0] trit(int prod, int lo, int hi);
            if (prod < lo)
                return TC_BELOW;
            if (prod > hi)
                return TC_ABOVE;
            return TC_INSIDE;
        endfunction

        // advance the model by one grid position and queue any code it yields
        function void take_pixel(logic [PIX_W-1:0] pix);
            int unsigned      w, h, x, y;
            logic [PIX_W-1:0] top, mid, bot;
            int               c, lo, hi, prod, code;
            int               pa [NPAIRS];
            int               pb [NPAIRS];
            result_t          res;
            w   = eff_width();
            h   = eff_height();
            x   = col;
            y   = row;
            top = '0;
            mid = '0;
            bot = '0;
            if (x < w && y < h)
                bot = pix;
            if (x < w) begin
                if (y >= 1)
                    mid = line_above[x];
                if (y >= 2)
                    top = line_two_above[x];
                line_two_above[x] = line_above[x];
                line_above[x]     = bot;
            end
            for (int i = 0; i < 3; i++) begin
                win[i][0] = (x == 0) ? '0 : win[i][1];
                win[i][1] = (x == 0) ? '0 : win[i][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = bot;
            if (x >= 1 && y >= 1 && x <= w && y <= h) begin
                c  = win[1][1];
                lo = q16_round_even(c * (65536 - int'(tau_reg)));
                hi = q16_round_even(c * (65536 + int'(tau_reg)));
                if (hi > 255)
                    hi = 255;
                pa[0] = win[1][2]; pb[0] = win[1][0];
                pa[1] = win[2][2]; pb[1] = win[0][0];
                pa[2] = win[2][1]; pb[2] = win[0][1];
                pa[3] = win[2][0]; pb[3] = win[0][2];
                code = 0;
                for (int k = 0; k < NPAIRS; k++) begin
                    prod = (pa[k] - c) * (pb[k] - c);
                    code += int'(PAIR_WEIGHT[k]) * int'(trit(prod, lo, hi));
                end
                res.code = CODE_W'(code);
                res.eol  = (x == w);
                res.eoi  = (x == w && y == h);
                pending_codes.push_back(res);
            end
            if (x >= w) begin
                col = 0;
                row = (y >= h) ? 0 : y + 1;
            end else begin
                col = x + 1;
            end
        endfunction

        function void report(string what, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected code %0d eol %0b eoi %0b, got code %0d eol %0b eoi %0b",
                         what, want.code, want.eol, want.eoi, got.code, got.eol, got.eoi);
        endfunction

        function void check_code(result_t got);
            result_t want;
            if (pending_codes.size() == 0) begin
                report("code with none pending", '0, got);
                return;
            end
            want = pending_codes.pop_front();
            if (got.code !== want.code || got.eol !== want.eol || got.eoi !== want.eoi)
                report("code mismatch", want, got);
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_write    = 1'b0;
    logic [CIDX_W-1:0] cfg_index    = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]  cfg_data     = '0;
    logic              push         = 1'b0;
    logic              full;
    logic [PIX_W-1:0]  pixel        = '0;
    logic              empty;
    logic              pop          = 1'b0;
    logic [CODE_W-1:0] pattern_code;
    logic              end_of_line;
    logic              end_of_image;

    code_scoreboard sb = new();

    // steady: both sides run flat out, no idle cycles
    bit steady = 1'b0;
    // grey level around which the flat-ish pixels of an image cluster
    int level  = 128;
    // words accepted on the pixel side so far
    int fed    = 0;
    int idle_cycles = 0;

    cs_siltp_3x3_texture_code #(
        .MAX_WIDTH(LINE_MAX)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .pixel       (pixel),
        .empty       (empty),
        .pop         (pop),
        .pattern_code(pattern_code),
        .end_of_line (end_of_line),
        .end_of_image(end_of_image)
    );

    always #2 clk = ~clk;

    // hang detector: any accepted word or register write restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_write)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // offer one pixel word after a random gap and hold it until the dut takes it
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        pixel <= value;
        @(posedge clk);
        // full is sampled before the edge updates land, so this is the dut's view
        while (full) @(posedge clk);
        sb.take_pixel(value);
        fed++;
    endtask

    // stop sending and let every owed code drain out, plus a latency margin
    task automatic settle();
        push <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // one register write; the trailing wait with cfg_write low keeps it to one update per step
    task automatic load_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int w, input int h, input int tau);
        settle();
        load_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
        load_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
        load_reg(CFG_TAU_SCALE, CFG_W'(tau));
    endtask

    // mix of saturated, uniform and near-level values so that all three
    // ternary outcomes turn up often
    function automatic logic [PIX_W-1:0] pick_pixel();
        int sel;
        int v;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        if (sel < 4)
            return PIX_W'($urandom_range(0, 255));
        v = level + int'($urandom_range(0, 8)) - 4;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return PIX_W'(v);
    endfunction

    // feed a whole padded image; optionally stop part way, drain, and change
    // one register before carrying on (width never grows mid-image so
    // no unwritten line buffer entry is read)
    task automatic run_image(input bit may_break);
        int positions;
        int cut;
        int n;
        positions = (sb.eff_width() + 1) * (sb.eff_height() + 1);
        cut       = 0;
        n         = 0;
        level     = $urandom_range(0, 255);
        if (may_break && $urandom_range(0, 3) == 0)
            cut = $urandom_range(1, positions - 1);
        do
        begin
            send_pixel(pick_pixel());
            n++;
            if (n == cut)
            begin
                settle();
                case ($urandom_range(0, 2))
                    0: load_reg(CFG_IMAGE_WIDTH, CFG_W'($urandom_range(1, sb.eff_width())));
                    1: load_reg(CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, 8)));
                    default: load_reg(CFG_TAU_SCALE, CFG_W'($urandom_range(0, 65535)));
                endcase
            end
        end
        while (sb.col != 0 || sb.row != 0);
    endtask

    // result side: random stall before each word, then wait for one to show
    initial
    begin
        int      stall;
        result_t got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            got.code = pattern_code;
            got.eol  = end_of_line;
            got.eoi  = end_of_image;
            sb.check_code(got);
        end
    end

    initial
    begin
        logic [PIX_W-1:0] lit [12];
        int               k;
        int               start;
        int               w_pick;
        int               h_pick;
        int               tau_pick;
        lit = '{8'd0, 8'd255, 8'h55, 8'hAA, 8'd1, 8'd254,
                8'd128, 8'd127, 8'd200, 8'd200, 8'd0, 8'd255};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start of row 0 with the reset geometry: no codes can appear yet
        for (k = 0; k < 12; k++)
            send_pixel(lit[k]);
        // shrink the image under the counters: the next word lies past the
        // new width, closes the row silently, and the image ends after row 2
        settle();
        load_reg(CFG_IMAGE_WIDTH, CFG_W'(4));
        load_reg(CFG_IMAGE_HEIGHT, CFG_W'(2));
        load_reg(CFG_TAU_SCALE, CFG_W'(0));
        k = 0;
        do
        begin
            send_pixel(lit[k % 12]);
            k++;
        end
        while (sb.col != 0 || sb.row != 0);

        // zero width and height read as one, with the widest tolerance
        set_geometry(0, 0, 65535);
        for (k = 0; k < 4; k++)
            send_pixel(lit[8 + k]);

        // one pixel wide and fairly tall, flat out
        set_geometry(1, 20, 65535);
        steady = 1'b1;
        run_image(1'b0);
        steady = 1'b0;

        // random part: mostly small images, now and then broken mid-image
        start = fed;
        while (fed - start < 830)
        begin
            w_pick = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 15) == 1)
                w_pick = $urandom_range(13, 40);
            h_pick = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
            case ($urandom_range(0, 7))
                0:       tau_pick = 0;
                1:       tau_pick = 65535;
                2, 3:    tau_pick = $urandom_range(0, 4000);
                default: tau_pick = $urandom_range(0, 65535);
            endcase
            set_geometry(w_pick, h_pick, tau_pick);
            repeat ($urandom_range(1, 3))
            begin
                steady = ($urandom_range(0, 3) == 0);
                run_image(1'b1);
            end
        end
        steady = 1'b0;

        // let the last codes out, then give stray words a chance to show
        push <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (3 * DRAIN_WAIT) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/csltp_pkg.sv
rtl/core/csltp_fifo.sv
rtl/core/csltp_front.sv
rtl/core/csltp_back.sv
rtl/core/cs_siltp_3x3_texture_code.sv
sim/tb_cs_siltp_3x3_texture_code.sv
